>>> sv/b64e_pkg.sv
// Shared types, constants and the alphabet function for the base64 stream encoder.
package b64e_pkg;

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [6:0] PAD_CHAR   = 7'h3D;
    localparam logic [6:0] PLUS_CHAR  = 7'h2B;
    localparam logic [6:0] SLASH_CHAR = 7'h2F;
    localparam logic [6:0] UPPER_OFS  = 7'd65;
    localparam logic [6:0] LOWER_OFS  = 7'd71;
    localparam logic [6:0] DIGIT_SUB  = 7'd4;

    typedef enum logic [1:0] {
        PHASE_0,
        PHASE_1,
        PHASE_2
    } b64e_phase_t;

    // Up to four characters produced by one input item.
    typedef struct packed {
        logic [3:0][5:0] sextet;
        logic [3:0]      pad;
        logic [1:0]      last_idx;
        logic            eot;
    } b64e_group_t;

    function automatic logic [6:0] sextet_char(input logic [5:0] v);
        logic [6:0] r;
        if (v < 6'd26)
            r = {1'b0, v} + UPPER_OFS;
        else if (v < 6'd52)
            r = {1'b0, v} + LOWER_OFS;
        else if (v < 6'd62)
            r = {1'b0, v} - DIGIT_SUB;
        else if (v == 6'd62)
            r = PLUS_CHAR;
        else
            r = SLASH_CHAR;
        return r;
    endfunction

endpackage

>>> sv/b64e_front.sv
// Front end: accepts bytes, tracks phase and leftover bits, builds character groups.
module b64e_front
    import b64e_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_ready,
    input  logic [7:0]  data_byte,
    input  logic        final_byte,
    input  logic        fifo_full,
    output logic        push,
    output b64e_group_t group
);

    b64e_phase_t phase_reg, phase_next;
    logic [3:0]  lo_reg, lo_next;
    b64e_phase_t ph_mid;
    logic [3:0]  lo_mid;
    logic        accept;

    assign byte_ready = !fifo_full;
    assign accept     = byte_valid && !fifo_full;
    assign push       = accept;

    always_comb
    begin
        group      = '0;
        ph_mid     = PHASE_0;
        lo_mid     = '0;
        unique case (phase_reg)
            PHASE_1:
            begin
                group.sextet[0] = {lo_reg[1:0], data_byte[7:4]};
                group.last_idx  = 2'd0;
                lo_mid          = data_byte[3:0];
                ph_mid          = PHASE_2;
            end
            PHASE_2:
            begin
                group.sextet[0] = {lo_reg[3:0], data_byte[7:6]};
                group.sextet[1] = data_byte[5:0];
                group.last_idx  = 2'd1;
                lo_mid          = '0;
                ph_mid          = PHASE_0;
            end
            default:
            begin
                group.sextet[0] = data_byte[7:2];
                group.last_idx  = 2'd0;
                lo_mid          = {2'b00, data_byte[1:0]};
                ph_mid          = PHASE_1;
            end
        endcase

        phase_next = ph_mid;
        lo_next    = lo_mid;
        if (final_byte)
        begin
            group.eot = 1'b1;
            if (ph_mid == PHASE_1)
            begin
                group.sextet[1] = {lo_mid[1:0], 4'b0000};
                group.pad[2]    = 1'b1;
                group.pad[3]    = 1'b1;
                group.last_idx  = 2'd3;
            end
            else if (ph_mid == PHASE_2)
            begin
                group.sextet[1] = {lo_mid, 2'b00};
                group.pad[2]    = 1'b1;
                group.last_idx  = 2'd2;
            end
            phase_next = PHASE_0;
            lo_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PHASE_0;
            lo_reg    <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            lo_reg    <= lo_next;
        end
    end

`ifndef SYNTH
    a_final_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        accept && final_byte |=> phase_reg == PHASE_0 && lo_reg == 4'd0)
        else $error("phase not cleared after final item");
`endif

endmodule

>>> sv/b64e_fifo.sv
// Short queue of character groups between front and back ends.
module b64e_fifo
    import b64e_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  b64e_group_t push_data,
    input  logic        pop,
    output b64e_group_t head,
    output logic        empty,
    output logic        full
);

    b64e_group_t                 entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0]       count_reg, count_next;
    logic                        do_push, do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        count_next = count_reg + FIFO_CNT_W'(do_push) - FIFO_CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full queue");
`endif

endmodule

>>> sv/b64e_back.sv
// Back end: serialises queued groups into one registered character per cycle while char_ready does not stall it.
module b64e_back
    import b64e_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  b64e_group_t head,
    input  logic        empty,
    output logic        pop,
    output logic        char_valid,
    input  logic        char_ready,
    output logic [6:0]  out_char,
    output logic        end_of_text
);

    logic [1:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [6:0] char_reg;
    logic       eot_reg;
    logic       load, take, last;
    logic [6:0] cur_char;

    assign load     = !valid_reg || char_ready;
    assign take     = load && !empty;
    assign last     = (idx_reg == head.last_idx);
    assign pop      = take && last;
    assign cur_char = head.pad[idx_reg] ? PAD_CHAR : sextet_char(head.sextet[idx_reg]);

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load)
            valid_next = !empty;
        if (take)
            idx_next = last ? 2'd0 : idx_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            char_reg <= cur_char;
            eot_reg  <= last && head.eot;
        end
    end

    assign char_valid  = valid_reg;
    assign out_char    = char_reg;
    assign end_of_text = eot_reg;

`ifndef SYNTH
    a_idx_in_group: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> idx_reg <= head.last_idx)
        else $error("character index beyond group");
    a_idle_idx: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> idx_reg == 2'd0)
        else $error("index not reset with empty queue");
`endif

endmodule

>>> sv/base64_stream_encoder.sv
// Top level of the base64 stream encoder: front end, group queue, back end.
// A byte's group is registered in the queue, then its first character in the output register.
// Throughput: one character per cycle from the back end while char_ready does not stall it and the
// queue is not empty; a byte gives one or two characters and a final byte up to four.
// The two-entry group queue lets the front end take bytes while characters drain.
// Reset (rst_n low, asynchronous) empties the queue and output and clears phase and leftover bits.
module base64_stream_encoder
    import b64e_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_ready,
    input  logic [7:0] data_byte,
    input  logic       final_byte,
    output logic       char_valid,
    input  logic       char_ready,
    output logic [6:0] out_char,
    output logic       end_of_text
);

    b64e_group_t group;
    b64e_group_t head;
    logic        push, pop, empty, full;

    b64e_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .data_byte  (data_byte),
        .final_byte (final_byte),
        .fifo_full  (full),
        .push       (push),
        .group      (group)
    );

    b64e_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (group),
        .pop       (pop),
        .head      (head),
        .empty     (empty),
        .full      (full)
    );

    b64e_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .empty       (empty),
        .pop         (pop),
        .char_valid  (char_valid),
        .char_ready  (char_ready),
        .out_char    (out_char),
        .end_of_text (end_of_text)
    );

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for base64_stream_encoder: directed and random messages, char checker.
`timescale 1ns / 1ps

module tb_top
    import b64e_pkg::*;
();

    typedef struct packed {
        logic [6:0] ch;
        logic       eot;
    } b64_char_t;

    class char_stream_check;
        localparam bit [8*64-1:0] ALPHABET =
            "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

        b64e_phase_t phase;
        logic [3:0]  carry;
        b64_char_t   chars_due[$];
        int          mismatches;

        function new();
            phase      = PHASE_0;
            carry      = 4'h0;
            mismatches = 0;
        endfunction

        function logic [6:0] sextet_symbol(input logic [5:0] v);
            logic [7:0] c;
            c = ALPHABET[8*(63 - v) +: 8];
            return c[6:0];
        endfunction

        // Work out the characters one accepted item gives and queue them.
        function void take_byte(input logic [7:0] b, input logic fin);
            b64_char_t got[4];
            int        n;
            n = 0;
            case (phase)
                PHASE_1:
                begin
                    got[n++] = '{sextet_symbol({carry[1:0], b[7:4]}), 1'b0};
                    carry = b[3:0];
                    phase = PHASE_2;
                end
                PHASE_2:
                begin
                    got[n++] = '{sextet_symbol({carry, b[7:6]}), 1'b0};
                    got[n++] = '{sextet_symbol(b[5:0]), 1'b0};
                    carry = 4'h0;
                    phase = PHASE_0;
                end
                default:
                begin
                    got[n++] = '{sextet_symbol(b[7:2]), 1'b0};
                    carry = {2'b00, b[1:0]};
                    phase = PHASE_1;
                end
            endcase
            if (fin)
            begin
                if (phase == PHASE_1)
                begin
                    got[n++] = '{sextet_symbol({carry[1:0], 4'h0}), 1'b0};
                    got[n++] = '{PAD_CHAR, 1'b0};
                    got[n++] = '{PAD_CHAR, 1'b0};
                end
                else if (phase == PHASE_2)
                begin
                    got[n++] = '{sextet_symbol({carry, 2'b00}), 1'b0};
                    got[n++] = '{PAD_CHAR, 1'b0};
                end
                got[n-1].eot = 1'b1;
                carry = 4'h0;
                phase = PHASE_0;
            end
            for (int i = 0; i < n; i++)
                chars_due = {chars_due, got[i]};
        endfunction

        task report(input string msg);
            $display("MISMATCH @%0t: %s", $time, msg);
            mismatches++;
        endtask

        task match_char(input logic [6:0] ch, input logic eot);
            b64_char_t want;
            if (chars_due.size() == 0)
            begin
                report($sformatf("char 0x%02h eot %0b with nothing due", ch, eot));
                return;
            end
            want = chars_due.pop_front();
            if (ch !== want.ch)
                report($sformatf("out_char 0x%02h, want 0x%02h", ch, want.ch));
            if (eot !== want.eot)
                report($sformatf("end_of_text %0b, want %0b (char 0x%02h)", eot, want.eot,
                                 want.ch));
        endtask
    endclass

    localparam int HOLD_AFTER  = 60;
    localparam int HOLD_CYCLES = 200;

    logic       clk;
    logic       rst_n;
    logic       byte_valid;
    logic       byte_ready;
    logic [7:0] data_byte;
    logic       final_byte;
    logic       char_valid;
    logic       char_ready;
    logic [6:0] out_char;
    logic       end_of_text;

    char_stream_check checker_h = new();
    int               bytes_taken = 0;
    int               send_idle = 32;
    int               recv_idle = 64;

    base64_stream_encoder i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .data_byte  (data_byte),
        .final_byte (final_byte),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .out_char   (out_char),
        .end_of_text(end_of_text)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && char_valid && char_ready)
            checker_h.match_char(out_char, end_of_text);
    end

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_byte(input logic [7:0] b, input logic fin);
        while ($urandom_range(99) < send_idle)
        begin
            byte_valid <= 1'b0;
            @(negedge clk);
        end
        byte_valid <= 1'b1;
        data_byte  <= b;
        final_byte <= fin;
        @(posedge clk);
        while (!byte_ready)
            @(posedge clk);
        checker_h.take_byte(b, fin);
        bytes_taken++;
        @(negedge clk);
    endtask

    task automatic send_message(input int len);
        logic [7:0] b;
        for (int i = 0; i < len; i++)
        begin
            case ($urandom_range(7))
                0:       b = 8'h00;
                1:       b = 8'hFF;
                default: b = 8'($urandom_range(255));
            endcase
            send_byte(b, i == len - 1);
        end
    endtask

    task automatic random_messages(input int count);
        int target;
        int len;
        target = bytes_taken + count;
        while (bytes_taken < target)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(30, 18) : $urandom_range(9, 1);
            send_message(len);
        end
    endtask

    // Receiver: random ready, with one long hold-off once traffic is flowing.
    initial
    begin
        bit held;
        held = 1'b0;
        char_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!held && bytes_taken >= HOLD_AFTER)
            begin
                held = 1'b1;
                char_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            char_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    initial
    begin
        logic [47:0] leads;
        leads      = 48'h64_68_CC_D0_F4_F8;
        rst_n      = 1'b0;
        byte_valid = 1'b0;
        data_byte  = 8'h00;
        final_byte = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // one-byte messages, a two-byte tail, a full group ending on the final byte
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFC, 1'b0);
        send_byte(8'hF8, 1'b0);
        send_byte(8'hF4, 1'b1);
        // alphabet boundaries as leading sextets
        for (int i = 0; i < 6; i++)
        begin
            send_byte(leads[8*(5 - i) +: 8], i == 5);
            if (i < 5)
            begin
                send_byte(8'h00, 1'b0);
                send_byte(8'h00, 1'b0);
            end
        end

        random_messages(45);
        send_idle = 64;
        recv_idle = 32;
        random_messages(45);
        send_idle = 0;
        recv_idle = 0;
        random_messages(44);
        byte_valid <= 1'b0;

        while (checker_h.chars_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (checker_h.mismatches == 0)
            $display("base64_stream_encoder regression: pass");
        else
            $display("base64_stream_encoder regression: fail");
        $finish;
    end

    initial
    begin
        #1ms;
        $display("TIMEOUT @%0t", $time);
        $display("base64_stream_encoder regression: fail");
        $finish;
    end

endmodule
